/* rtl/i2cmbe_pkg.sv */
// Package for the I2C master byte engine: payload structs, command and
// sequencer phase codes, sequencer state record and delay load helper.
// No dependencies.
package i2cmbe_pkg;

  localparam int DELAY_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam logic [CFG_BITS-1:0] HALF_PERIOD_RESET = 16'd10;
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST1  = 4'd1,
    PH_ST2  = 4'd2,
    PH_SP1  = 4'd3,
    PH_SP2  = 4'd4,
    PH_SP3  = 4'd5,
    PH_WD   = 4'd6,
    PH_WH   = 4'd7,
    PH_WA   = 4'd8,
    PH_WAH  = 4'd9,
    PH_RL   = 4'd10,
    PH_RH   = 4'd11,
    PH_RA   = 4'd12,
    PH_RAH  = 4'd13
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] action;
    logic [7:0] tx_byte;
    logic       ack_on_read;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic [7:0] rx_byte;
  } out_item_t;

  typedef struct packed {
    phase_t                phase;
    logic [3:0]            bit_count;
    logic [7:0]            shift_reg;
    logic [DELAY_BITS-1:0] delay_count;
    logic                  ack_flag;
    logic                  scl_low;
    logic                  sda_low;
    logic                  ack_choice;
    logic [7:0]            rx_hold;
  } seq_state_t;

  // Delay reload: zero acts as one, saturate to the counter range.
  function automatic logic [DELAY_BITS-1:0] delay_load(input logic [CFG_BITS-1:0] h);
    logic [31:0] h32;
    logic [31:0] max32;
    h32   = 32'(h);
    max32 = 32'((64'd1 << DELAY_BITS) - 64'd1);
    if (h32 == 32'd0) begin
      h32 = 32'd1;
    end
    if (h32 > max32) begin
      h32 = max32;
    end
    return h32[DELAY_BITS-1:0];
  endfunction

endpackage

/* rtl/i2cmbe_step.sv */
// Next-state logic of the I2C byte sequencer for one system tick.
// Depends on i2cmbe_pkg.
module i2cmbe_step (
  input  i2cmbe_pkg::seq_state_t cur,
  input  i2cmbe_pkg::in_item_t   item,
  input  logic [i2cmbe_pkg::CFG_BITS-1:0] half_period,
  output i2cmbe_pkg::seq_state_t nxt,
  output logic                   done
);
  import i2cmbe_pkg::*;

  logic [DELAY_BITS-1:0] ld;
  logic [DELAY_BITS-1:0] dc;
  logic [3:0]            bc;

  assign ld = delay_load(half_period);
  assign dc = cur.delay_count - DELAY_BITS'(cur.delay_count != '0);
  assign bc = cur.bit_count + 4'd1;

  always_comb begin
    nxt  = cur;
    done = 1'b0;
    if (cur.phase == PH_IDLE) begin
      if (item.cmd_valid) begin
        nxt.bit_count   = 4'd0;
        nxt.delay_count = ld;
        unique case (action_t'(item.action))
          ACT_START: begin
            nxt.sda_low = 1'b0;
            nxt.scl_low = 1'b0;
            nxt.phase   = PH_ST1;
          end
          ACT_STOP: begin
            nxt.sda_low = 1'b1;
            nxt.phase   = PH_SP1;
          end
          ACT_WRITE: begin
            nxt.sda_low   = ~item.tx_byte[7];
            nxt.shift_reg = {item.tx_byte[6:0], 1'b0};
            nxt.phase     = PH_WD;
          end
          default: begin
            nxt.shift_reg  = 8'd0;
            nxt.ack_choice = item.ack_on_read;
            nxt.sda_low    = 1'b0;
            nxt.phase      = PH_RL;
          end
        endcase
      end
    end else begin
      nxt.delay_count = dc;
      if (dc == '0) begin
        nxt.delay_count = ld;
        unique case (cur.phase)
          PH_ST1: begin nxt.sda_low = 1'b1; nxt.phase = PH_ST2; end
          PH_ST2: begin nxt.scl_low = 1'b1; done = 1'b1; end
          PH_SP1: begin nxt.scl_low = 1'b0; nxt.phase = PH_SP2; end
          PH_SP2: begin nxt.sda_low = 1'b0; nxt.phase = PH_SP3; end
          PH_SP3: done = 1'b1;
          PH_WD:  begin nxt.scl_low = 1'b0; nxt.phase = PH_WH; end
          PH_WH: begin
            nxt.scl_low   = 1'b1;
            nxt.bit_count = bc;
            if (bc < BITS_PER_BYTE) begin
              nxt.sda_low   = ~cur.shift_reg[7];
              nxt.shift_reg = {cur.shift_reg[6:0], 1'b0};
              nxt.phase     = PH_WD;
            end else begin
              nxt.sda_low = 1'b0;
              nxt.phase   = PH_WA;
            end
          end
          PH_WA:  begin nxt.scl_low = 1'b0; nxt.phase = PH_WAH; end
          PH_WAH: begin
            nxt.ack_flag = ~item.sda_in;
            nxt.scl_low  = 1'b1;
            done         = 1'b1;
          end
          PH_RL:  begin nxt.scl_low = 1'b0; nxt.phase = PH_RH; end
          PH_RH: begin
            nxt.shift_reg = {cur.shift_reg[6:0], item.sda_in};
            nxt.scl_low   = 1'b1;
            nxt.bit_count = bc;
            if (bc < BITS_PER_BYTE) begin
              nxt.phase = PH_RL;
            end else begin
              nxt.sda_low = cur.ack_choice;
              nxt.phase   = PH_RA;
            end
          end
          PH_RA:  begin nxt.scl_low = 1'b0; nxt.phase = PH_RAH; end
          PH_RAH: begin
            nxt.scl_low = 1'b1;
            nxt.sda_low = 1'b0;
            nxt.rx_hold = cur.shift_reg;
            done        = 1'b1;
          end
          default: done = 1'b1;
        endcase
        if (done) begin
          nxt.phase       = PH_IDLE;
          nxt.delay_count = '0;
        end
      end
    end
  end

endmodule

/* rtl/i2c_master_byte_engine_core.sv */
// Top level of the I2C master byte engine: sequencer state register,
// result register and configuration register. Depends on i2cmbe_pkg and i2cmbe_step.
//
// Each transfer on the input channel is one system tick of the bus sequencer
// and produces exactly one transfer on the output channel carrying the line
// drive, busy, done, last ACK and last read byte after that tick. The block
// takes one input transfer per cycle: the sequencer state and the result
// register both update in the accepting cycle, and in_ready stays high as
// long as the result register is empty or being drained in the same cycle.
// A back-pressured output holds in_ready low until its result is taken. The
// half period register sets how many ticks (not cycles) each bus delay lasts;
// a value of zero acts as one. Write it only while no command is running.
module i2c_master_byte_engine_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  i2cmbe_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output i2cmbe_pkg::out_item_t             out_data,
  input  logic                              cfg_we,
  input  logic [i2cmbe_pkg::CFG_BITS-1:0]   cfg_data
);
  import i2cmbe_pkg::*;

  logic [CFG_BITS-1:0] half_period;
  seq_state_t          state;
  seq_state_t          state_next;
  logic                step_done;
  logic                accept;

  // Accept when the result slot is free or is emptied this cycle.
  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  i2cmbe_step u_step (
    .cur         (state),
    .item        (in_data),
    .half_period (half_period),
    .nxt         (state_next),
    .done        (step_done)
  );

  // Hold the half period until rewritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_we) begin
      half_period <= cfg_data;
    end
  end

  // Advance the sequencer by one tick per accepted transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_IDLE;
      state.bit_count   <= 4'd0;
      state.shift_reg   <= 8'd0;
      state.delay_count <= '0;
      state.ack_flag    <= 1'b0;
      state.scl_low     <= 1'b0;
      state.sda_low     <= 1'b0;
      state.ack_choice  <= 1'b0;
      state.rx_hold     <= 8'd0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Result register: valid flag is control, payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.scl_pull_low <= state_next.scl_low;
      out_data.sda_pull_low <= state_next.sda_low;
      out_data.busy_res     <= (state_next.phase != PH_IDLE);
      out_data.done_res     <= step_done;
      out_data.ack_received <= state_next.ack_flag;
      out_data.rx_byte      <= state_next.rx_hold;
    end
  end

endmodule
